### design/atan2_ra_pkg.sv
// shared types, constants and coefficient tables of the arctangent pipeline
package atan2_ra_pkg;

	localparam int SAMPLE_WIDTH_DEF    = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 13;

	localparam int ANGLE_W = 16;
	localparam int Z_W     = 32;
	localparam int S_W     = 28;
	localparam int PW      = 36;
	localparam int R_W     = 30;
	localparam int T_W     = 34;
	localparam int MW      = 35;
	localparam int HORNER_STEPS = 4;

	localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd32767;

	// coefficients rounded to q24
	localparam logic [63:0] KW_P4 = (64'd161536412982 * 64'd16777216 + 64'd5000000000) / 64'd10000000000;
	localparam logic [63:0] KW_P3 = (64'd268425481955 * 64'd16777216 + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] KW_P2 = (64'd115302935154 * 64'd16777216 + 64'd50000000) / 64'd100000000;
	localparam logic [63:0] KW_P1 = (64'd178040631643 * 64'd16777216 + 64'd50000000) / 64'd100000000;
	localparam logic [63:0] KW_P0 = (64'd896785974037 * 64'd16777216 + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] KW_Q4 = (64'd589569705084 * 64'd16777216 + 64'd5000000000) / 64'd10000000000;
	localparam logic [63:0] KW_Q3 = (64'd536265374031 * 64'd16777216 + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] KW_Q2 = (64'd166678381488 * 64'd16777216 + 64'd50000000) / 64'd100000000;
	localparam logic [63:0] KW_Q1 = (64'd207933497445 * 64'd16777216 + 64'd50000000) / 64'd100000000;
	localparam logic [63:0] KW_Q0 = (64'd896785974037 * 64'd16777216 + 64'd500000000) / 64'd1000000000;

	localparam logic [PW-1:0] K_P [0:HORNER_STEPS] = '{
		KW_P4[PW-1:0], KW_P3[PW-1:0], KW_P2[PW-1:0], KW_P1[PW-1:0], KW_P0[PW-1:0]};
	localparam logic [PW-1:0] K_Q [0:HORNER_STEPS] = '{
		KW_Q4[PW-1:0], KW_Q3[PW-1:0], KW_Q2[PW-1:0], KW_Q1[PW-1:0], KW_Q0[PW-1:0]};

	localparam logic [MW-1:0] PI_Q32   = 35'h3243F6A89;
	localparam logic [MW-1:0] PIO2_Q32 = 35'h1921FB544;
	localparam logic [MW-1:0] PIO4_Q32 = 35'h0C90FDAA2;

	localparam logic [1:0] MODE_LOW  = 2'd0;
	localparam logic [1:0] MODE_HIGH = 2'd1;
	localparam logic [1:0] MODE_MIDP = 2'd2;
	localparam logic [1:0] MODE_MIDM = 2'd3;

	typedef struct packed {
		logic       c_zero;
		logic       s_zero;
		logic       c_neg;
		logic       neg;
		logic [1:0] mode;
	} side_t;

endpackage

### design/atan2_ra_div.sv
// pipelined restoring divider, one quotient bit per stage
module atan2_ra_div #(
	parameter int NW = 48,
	parameter int DW = 17,
	parameter int QB = 32,
	parameter int TW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic          out_vld,
	output logic [QB-1:0] quo,
	output logic [TW-1:0] tag_out
);

	localparam int WW = (NW > DW + QB) ? NW : DW + QB;

	logic [WW-1:0] rem_s [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic [TW-1:0] tag_s [0:QB];
	logic          vld_s [0:QB];

	assign rem_s[0] = WW'(num);
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign tag_s[0] = tag_in;
	assign vld_s[0] = in_vld;

	for (genvar i = 0; i < QB; i++) begin : g_stage
		localparam int B = QB - 1 - i;
		logic [WW-1:0] dsh;
		logic [WW:0]   diff;
		logic          ge;

		assign dsh  = WW'(den_s[i]) << B;
		assign diff = {1'b0, rem_s[i]} - {1'b0, dsh};
		assign ge   = !diff[WW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[WW-1:0] : rem_s[i];
				quo_s[i+1] <= {quo_s[i][QB-2:0], ge};
				den_s[i+1] <= den_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_vld = vld_s[QB];
	assign quo     = quo_s[QB];
	assign tag_out = tag_s[QB];

endmodule

### design/atan2_rational_approx.sv
// four-quadrant arctangent of two signed samples, Q3.13 radians, fully pipelined
// One request enters per clock while the output is not stalled; the angle passes through
// 4 front stages, a 32-stage divider for the reduced ratio, 10 stages of
// squaring and Horner evaluation, a 30-stage divider for the rational quotient,
// and 5 stages of scaling, quadrant folding and rounding. The pipeline moves as
// a whole: it advances whenever the output register is empty or being taken.
module atan2_rational_approx import atan2_ra_pkg::*; #(
	parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// sine_side, cosine_side
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// angle
	output logic [ANGLE_W-1:0] m_axis_tdata
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int SHIFT = 32 - ANGLE_FRAC_BITS;
	localparam int SB    = $bits(side_t);
	localparam logic [MW:0] HALF = (MW+1)'(1) << (SHIFT - 1);

	logic en;
	logic out_vld_q;
	logic [ANGLE_W-1:0] angle_q;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = angle_q;

	// front end
	logic [SW-1:0] sx, sc;
	side_t sd_in;
	assign sx = s_axis_tdata[SW-1:0];
	assign sc = s_axis_tdata[2*SW-1:SW];
	always_comb begin
		sd_in.c_zero = (sc == '0);
		sd_in.s_zero = (sx == '0);
		sd_in.c_neg  = sc[SW-1];
		sd_in.neg    = (sd_in.c_zero || sd_in.c_neg) ? sx[SW-1] : (sx[SW-1] || sd_in.s_zero);
		sd_in.mode   = MODE_LOW;
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [SW-1:0] a_s1, b_s1, a_s2, b_s2, a_s3, b_s3;
	logic [SW:0] sum_s2, sum_s3;
	logic [2*SW+1:0] sq_s3, a2_s3, b2_s3;
	logic [SW:0] num_s4, den_s4;
	side_t sd_s1, sd_s2, sd_s3, sd_s4;

	logic low_c, high_c;
	logic [SW:0] num_c, den_c;
	logic [1:0] mode_c;
	always_comb begin
		low_c  = (a_s3 < b_s3) && (sq_s3 < b2_s3);
		high_c = (b_s3 < a_s3) && (sq_s3 < a2_s3);
		priority if (low_c) begin
			num_c  = {1'b0, a_s3};
			den_c  = {1'b0, b_s3};
			mode_c = MODE_LOW;
		end else if (high_c) begin
			num_c  = {1'b0, b_s3};
			den_c  = {1'b0, a_s3};
			mode_c = MODE_HIGH;
		end else if (a_s3 >= b_s3) begin
			num_c  = {1'b0, a_s3} - {1'b0, b_s3};
			den_c  = sum_s3;
			mode_c = MODE_MIDP;
		end else begin
			num_c  = {1'b0, b_s3} - {1'b0, a_s3};
			den_c  = sum_s3;
			mode_c = MODE_MIDM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= sx[SW-1] ? (~sx + 1'b1) : sx;
			b_s1   <= sc[SW-1] ? (~sc + 1'b1) : sc;
			sd_s1  <= sd_in;
			sum_s2 <= {1'b0, a_s1} + {1'b0, b_s1};
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			sd_s2  <= sd_s1;
			sq_s3  <= (2*SW+2)'(sum_s2) * (2*SW+2)'(sum_s2);
			a2_s3  <= ((2*SW+2)'(a_s2) * (2*SW+2)'(a_s2)) << 1;
			b2_s3  <= ((2*SW+2)'(b_s2) * (2*SW+2)'(b_s2)) << 1;
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			sum_s3 <= sum_s2;
			sd_s3  <= sd_s2;
			num_s4 <= num_c;
			den_s4 <= den_c;
			sd_s4  <= '{c_zero: sd_s3.c_zero, s_zero: sd_s3.s_zero, c_neg: sd_s3.c_neg,
				neg: sd_s3.neg, mode: mode_c};
		end
	end

	// reduced ratio z in q0.32
	logic          d1_vld;
	logic [Z_W-1:0] d1_quo;
	logic [SB-1:0] d1_tag;

	atan2_ra_div #(
		.NW(SW + 1 + Z_W),
		.DW(SW + 1),
		.QB(Z_W),
		.TW(SB)
	) u_div_ratio (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s4),
		.num({num_s4, {Z_W{1'b0}}}),
		.den(den_s4),
		.tag_in(sd_s4),
		.out_vld(d1_vld),
		.quo(d1_quo),
		.tag_out(d1_tag)
	);

	// square of z
	logic vld_s5;
	logic [Z_W-1:0] z_s5;
	logic [S_W-1:0] s_s5;
	side_t sd_s5;
	logic [2*Z_W-1:0] zz;
	assign zz = (2*Z_W)'(d1_quo) * (2*Z_W)'(d1_quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s5  <= d1_quo;
			s_s5  <= zz[2*Z_W-1:2*Z_W-S_W];
			sd_s5 <= side_t'(d1_tag);
		end
	end

	// horner evaluation of numerator and denominator
	logic [PW-1:0]      hp_s [0:HORNER_STEPS];
	logic [PW-1:0]      hq_s [0:HORNER_STEPS];
	logic [S_W-1:0]     hs_s [0:HORNER_STEPS];
	logic [Z_W-1:0]     hz_s [0:HORNER_STEPS];
	side_t              hsd_s [0:HORNER_STEPS];
	logic               hv_s [0:HORNER_STEPS];
	logic [PW+S_W-1:0]  mp_s [1:HORNER_STEPS];
	logic [PW+S_W-1:0]  mq_s [1:HORNER_STEPS];
	logic [S_W-1:0]     ms_s [1:HORNER_STEPS];
	logic [Z_W-1:0]     mz_s [1:HORNER_STEPS];
	side_t              msd_s [1:HORNER_STEPS];
	logic               mv_s [1:HORNER_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_s[0] <= 1'b0;
		end else if (en) begin
			hv_s[0] <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hp_s[0]  <= K_P[0];
			hq_s[0]  <= PW'(s_s5 >> 4) + K_Q[0];
			hs_s[0]  <= s_s5;
			hz_s[0]  <= z_s5;
			hsd_s[0] <= sd_s5;
		end
	end

	for (genvar k = 1; k <= HORNER_STEPS; k++) begin : g_horner
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mv_s[k] <= 1'b0;
				hv_s[k] <= 1'b0;
			end else if (en) begin
				mv_s[k] <= hv_s[k-1];
				hv_s[k] <= mv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mp_s[k]  <= (PW+S_W)'(hp_s[k-1]) * (PW+S_W)'(hs_s[k-1]);
				mq_s[k]  <= (PW+S_W)'(hq_s[k-1]) * (PW+S_W)'(hs_s[k-1]);
				ms_s[k]  <= hs_s[k-1];
				mz_s[k]  <= hz_s[k-1];
				msd_s[k] <= hsd_s[k-1];
				hp_s[k]  <= mp_s[k][PW+S_W-1:S_W] + K_P[k];
				hq_s[k]  <= mq_s[k][PW+S_W-1:S_W] + K_Q[k];
				hs_s[k]  <= ms_s[k];
				hz_s[k]  <= mz_s[k];
				hsd_s[k] <= msd_s[k];
			end
		end
	end

	// rational quotient r = (p << 28) / q
	logic           d2_vld;
	logic [R_W-1:0] d2_quo;
	logic [SB+Z_W-1:0] d2_tag;

	atan2_ra_div #(
		.NW(PW + 28),
		.DW(PW),
		.QB(R_W),
		.TW(SB + Z_W)
	) u_div_poly (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(hv_s[HORNER_STEPS]),
		.num({hp_s[HORNER_STEPS], 28'd0}),
		.den(hq_s[HORNER_STEPS]),
		.tag_in({hsd_s[HORNER_STEPS], hz_s[HORNER_STEPS]}),
		.out_vld(d2_vld),
		.quo(d2_quo),
		.tag_out(d2_tag)
	);

	// back end: scale, fold into quadrant, round
	logic vld_s7, vld_s8, vld_s9, vld_s10;
	logic [T_W-1:0] t_s7;
	logic [MW-1:0] w_s8, mag_s9;
	logic [ANGLE_W-1:0] rnd_s10;
	side_t sd_s7, sd_s8, sd_s9, sd_s10;

	logic [R_W+Z_W-1:0] rz;
	logic [MW-1:0] w_c, mag_c;
	logic [MW:0] rsum;
	logic [MW:0] rsh;

	assign rz   = (R_W+Z_W)'(d2_quo) * (R_W+Z_W)'(d2_tag[Z_W-1:0]);
	assign rsum = {1'b0, mag_s9} + HALF;
	assign rsh  = rsum >> SHIFT;

	always_comb begin
		unique case (sd_s7.mode)
			MODE_LOW:  w_c = MW'(t_s7);
			MODE_HIGH: w_c = PIO2_Q32 - MW'(t_s7);
			MODE_MIDP: w_c = PIO4_Q32 + MW'(t_s7);
			MODE_MIDM: w_c = PIO4_Q32 - MW'(t_s7);
			default:   w_c = MW'(t_s7);
		endcase
		if (sd_s8.c_zero) begin
			mag_c = sd_s8.s_zero ? '0 : PIO2_Q32;
		end else if (sd_s8.c_neg) begin
			mag_c = PI_Q32 - w_s8;
		end else begin
			mag_c = w_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			vld_s10   <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s7    <= d2_vld;
			vld_s8    <= vld_s7;
			vld_s9    <= vld_s8;
			vld_s10   <= vld_s9;
			out_vld_q <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s7    <= rz[R_W+Z_W-1:28];
			sd_s7   <= side_t'(d2_tag[SB+Z_W-1:Z_W]);
			w_s8    <= w_c;
			sd_s8   <= sd_s7;
			mag_s9  <= mag_c;
			sd_s9   <= sd_s8;
			rnd_s10 <= (rsh > (MW+1)'(ANGLE_MAX)) ? ANGLE_MAX : rsh[ANGLE_W-1:0];
			sd_s10  <= sd_s9;
			angle_q <= sd_s10.neg ? (~rnd_s10 + 1'b1) : rnd_s10;
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output register");

	a_ratio_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && !(sd_s5.c_zero && sd_s5.s_zero) |-> !z_s5[Z_W-1])
		else $error("reduced ratio not below one half");

	a_mag_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 |-> (mag_s9 <= PI_Q32))
		else $error("angle magnitude above pi");

endmodule

### verif/atan2_rational_approx_checker.sv
// checker for the arctangent pipeline: predicts each angle and compares it on output
module atan2_rational_approx_checker import atan2_ra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	output int          fail_count,
	output int          pending
);

	logic [15:0] angle_q[$];

	assign pending = angle_q.size();

	function automatic logic [63:0] atan_poly(input logic [63:0] z);
		logic [63:0] s, p, q, r;
		s = (z * z) >> 36;
		p = KW_P4;
		p = ((p * s) >> 28) + KW_P3;
		p = ((p * s) >> 28) + KW_P2;
		p = ((p * s) >> 28) + KW_P1;
		p = ((p * s) >> 28) + KW_P0;
		q = (s >> 4) + KW_Q4;
		q = ((q * s) >> 28) + KW_Q3;
		q = ((q * s) >> 28) + KW_Q2;
		q = ((q * s) >> 28) + KW_Q1;
		q = ((q * s) >> 28) + KW_Q0;
		r = (p << 28) / q;
		return (r * z) >> 28;
	endfunction

	function automatic logic [63:0] first_octant_angle(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] sum, sq;
		sum = a + b;
		sq = sum * sum;
		if (a < b && sq < 2 * b * b)
			return atan_poly((a << 32) / b);
		if (b < a && sq < 2 * a * a)
			return 64'(PIO2_Q32) - atan_poly((b << 32) / a);
		if (a >= b)
			return 64'(PIO4_Q32) + atan_poly(((a - b) << 32) / sum);
		return 64'(PIO4_Q32) - atan_poly(((b - a) << 32) / sum);
	endfunction

	function automatic logic [15:0] predict_angle(input logic signed [15:0] sn,
			input logic signed [15:0] cs);
		logic [63:0] a, b, mag, res, w;
		logic neg;
		a = (sn < 0) ? 64'(-32'(sn)) : 64'(sn);
		b = (cs < 0) ? 64'(-32'(cs)) : 64'(cs);
		if (cs == 0) begin
			mag = (sn == 0) ? 64'd0 : 64'(PIO2_Q32);
			neg = sn < 0;
		end else begin
			w = first_octant_angle(a, b);
			mag = (cs < 0) ? 64'(PI_Q32) - w : w;
			neg = (cs < 0) ? (sn < 0) : (sn <= 0);
		end
		res = (mag + (64'd1 << 18)) >> 19;
		if (res > 32767)
			res = 32767;
		if (neg)
			res = -res;
		return res[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				angle_q.push_back(predict_angle(s_axis_tdata[15:0], s_axis_tdata[31:16]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (angle_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected angle %0d", $signed(m_axis_tdata));
				end else begin
					if (angle_q[0] !== m_axis_tdata) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("angle mismatch: expected %0d got %0d",
								$signed(angle_q[0]), $signed(m_axis_tdata));
					end
					void'(angle_q.pop_front());
				end
			end
		end
	end

endmodule

### verif/atan2_rational_approx_tb.sv
// testbench top: drives sample pairs and stalls, gives the verdict
module atan2_rational_approx_tb;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	int          fail_count;
	int          pending;

	atan2_rational_approx dut (.*);

	atan2_rational_approx_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 4)) - 16'd2;
			3: return 16'($urandom_range(0, 200)) - 16'd100;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_pair(input logic [15:0] sn, input logic [15:0] cs);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {cs, sn};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stalls
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) < 20) begin
				m_axis_tready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(50, 200)) @(negedge clk);
		end
	end

	initial begin
		logic [15:0] dir_s[20];
		logic [15:0] dir_c[20];
		int t;
		dir_s = '{16'd0, 16'd5, 16'hFFFB, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h8000, 16'd1, 16'hFFFF, 16'd100, 16'd41, 16'd42, 16'd241, 16'd242,
			16'hFFFF, 16'd1, 16'h7FFF, 16'h8000};
		dir_c = '{16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
			16'h7FFF, 16'hFFFF, 16'hFFFF, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100,
			16'd1, 16'h8000, 16'd1, 16'hFFFF};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_s[i])
			send_pair(dir_s[i], dir_c[i]);
		repeat (430)
			send_pair(rand_sample(), rand_sample());
		s_axis_tvalid <= 1'b0;
		t = 0;
		while (pending != 0 && t < 200000) begin
			@(negedge clk);
			t++;
		end
		repeat (200) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
